// ===== rtl/cmf_pkg.sv =====
`default_nettype none

package cmf_pkg;

    // Widths fixed by the pixel format and the register file.
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIX_W      = CHAN_W * NUM_CHAN;
    localparam int SUM_W      = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;

    // Default geometry limits and register reset values.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Item kinds carried on the input tuser.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Per-item control handed from the raster controller to the datapath.
    typedef struct packed {
        logic emit;      // this request produces a result
        logic drain;     // result comes from the last-row drain
        logic interior;  // pixel has all four neighbors
        logic last;      // final pixel of the image
        logic sel;       // which line store held the previous row
    } cmf_ctl_t;

    // Truncated mean of five samples: floor(s / 5) as s * 3277 >> 14,
    // exact for every s up to 1279, which covers any sum of five 8-bit samples.
    function automatic logic [CHAN_W-1:0] mean5(input logic [SUM_W-1:0] s);
        logic [22:0] prod;
        prod = 23'(s) * 23'(3277);
        return prod[21:14];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cmf_line_store.sv =====
`default_nettype none

module cmf_line_store #(
    parameter int DEPTH = cmf_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [cmf_pkg::PIX_W-1:0]  wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_b,
    output logic      [cmf_pkg::PIX_W-1:0]  rd_data_a,
    output logic      [cmf_pkg::PIX_W-1:0]  rd_data_b
);

    logic [cmf_pkg::PIX_W-1:0] mem [DEPTH];
    logic [cmf_pkg::PIX_W-1:0] rd_a_reg;
    logic [cmf_pkg::PIX_W-1:0] rd_b_reg;

    // Reads return the contents from before a write in the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== rtl/cmf_ctrl.sv =====
`default_nettype none

module cmf_ctrl #(
    parameter int MAX_WIDTH  = cmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cmf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    input  wire logic [cmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cmf_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                             accept,
    input  wire logic                             func,
    output cmf_pkg::cmf_ctl_t                     ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]          addr_a,
    output logic [$clog2(MAX_WIDTH)-1:0]          addr_b,
    output logic                                  wr_en_a,
    output logic                                  wr_en_b
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW_W = (WW > cmf_pkg::CFG_W) ? WW : cmf_pkg::CFG_W;
    localparam int CMPH_W = (HW > cmf_pkg::CFG_W) ? HW : cmf_pkg::CFG_W;

    logic [cmf_pkg::CFG_W-1:0] width_reg;
    logic [cmf_pkg::CFG_W-1:0] height_reg;
    logic [CW-1:0]             col_reg;
    logic [RW-1:0]             row_reg;
    logic [CW-1:0]             drain_reg;
    logic                      draining_reg;
    logic                      sel_reg;

    logic [CMPW_W-1:0] w_ext;
    logic [CMPH_W-1:0] h_ext;
    logic [WW-1:0]     w_use;
    logic [HW-1:0]     h_use;
    logic [WW-1:0]     col_inc;
    logic [HW-1:0]     row_inc;
    logic [WW-1:0]     drain_inc;
    logic              row_end;
    logic              img_end;
    logic              drain_end;
    logic              is_pixel;

    // Geometry in use saturates to three through the configured maximum.
    always_comb
    begin
        w_ext = CMPW_W'(width_reg);
        h_ext = CMPH_W'(height_reg);
        if (w_ext < CMPW_W'(3))
        begin
            w_ext = CMPW_W'(3);
        end
        else if (w_ext > CMPW_W'(MAX_WIDTH))
        begin
            w_ext = CMPW_W'(MAX_WIDTH);
        end
        if (h_ext < CMPH_W'(3))
        begin
            h_ext = CMPH_W'(3);
        end
        else if (h_ext > CMPH_W'(MAX_HEIGHT))
        begin
            h_ext = CMPH_W'(MAX_HEIGHT);
        end
        w_use = WW'(w_ext);
        h_use = HW'(h_ext);
    end

    assign col_inc   = WW'(col_reg) + WW'(1);
    assign row_inc   = HW'(row_reg) + HW'(1);
    assign drain_inc = WW'(drain_reg) + WW'(1);
    assign row_end   = col_inc >= w_use;
    assign img_end   = row_inc >= h_use;
    assign drain_end = drain_inc >= w_use;
    assign is_pixel  = (func == cmf_pkg::FUNC_PIXEL);

    always_comb
    begin
        ctl.emit     = is_pixel ? (!draining_reg && (row_reg != '0)) : draining_reg;
        ctl.drain    = !is_pixel;
        ctl.interior = (row_reg >= RW'(2)) && (col_reg != '0) && !row_end;
        ctl.last     = !is_pixel && drain_end;
        ctl.sel      = sel_reg;
    end

    // Port A reads the center (or the drained pixel), port B the right neighbor.
    assign addr_a  = is_pixel ? col_reg : drain_reg;
    assign addr_b  = col_inc[CW-1:0];
    assign wr_en_a = accept && is_pixel && !draining_reg && sel_reg;
    assign wr_en_b = accept && is_pixel && !draining_reg && !sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= cmf_pkg::RST_IMAGE_WIDTH;
            height_reg   <= cmf_pkg::RST_IMAGE_HEIGHT;
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
            sel_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    cmf_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    cmf_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                if (is_pixel && !draining_reg)
                begin
                    if (row_end)
                    begin
                        col_reg <= '0;
                        sel_reg <= !sel_reg;
                        if (img_end)
                        begin
                            draining_reg <= 1'b1;
                        end
                        else
                        begin
                            row_reg <= row_inc[RW-1:0];
                        end
                    end
                    else
                    begin
                        col_reg <= col_inc[CW-1:0];
                    end
                end
                else if (!is_pixel && draining_reg)
                begin
                    if (drain_end)
                    begin
                        draining_reg <= 1'b0;
                        drain_reg    <= '0;
                        row_reg      <= '0;
                        col_reg      <= '0;
                    end
                    else
                    begin
                        drain_reg <= drain_inc[CW-1:0];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cmf_mean.sv =====
`default_nettype none

module cmf_mean (
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire logic                       interior,
    input  wire logic                       drain,
    input  wire logic                       last,
    input  wire logic [cmf_pkg::PIX_W-1:0]  centre,
    input  wire logic [cmf_pkg::PIX_W-1:0]  right,
    input  wire logic [cmf_pkg::PIX_W-1:0]  up,
    input  wire logic [cmf_pkg::PIX_W-1:0]  down,
    output logic      [cmf_pkg::PIX_W-1:0]  pix,
    output logic                            pix_last
);

    logic [cmf_pkg::PIX_W-1:0] left_reg;
    logic [cmf_pkg::PIX_W-1:0] pix_reg;
    logic                      last_reg;
    logic [cmf_pkg::PIX_W-1:0] pix_next;
    logic [cmf_pkg::PIX_W-1:0] avg;

    // One adder chain and one reciprocal multiply per channel.
    always_comb
    begin
        for (int k = 0; k < cmf_pkg::NUM_CHAN; k++)
        begin
            avg[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W] = cmf_pkg::mean5(
                cmf_pkg::SUM_W'(centre[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W]) +
                cmf_pkg::SUM_W'(right[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W]) +
                cmf_pkg::SUM_W'(up[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W]) +
                cmf_pkg::SUM_W'(down[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W]) +
                cmf_pkg::SUM_W'(left_reg[k*cmf_pkg::CHAN_W +: cmf_pkg::CHAN_W]));
        end
        pix_next = interior ? avg : centre;
    end

    // The left neighbor is the center of the previous pixel of the same row.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg  <= pix_next;
            last_reg <= last;
            if (!drain)
            begin
                left_reg <= centre;
            end
        end
    end

    assign pix      = pix_reg;
    assign pix_last = last_reg;

endmodule

`default_nettype wire

// ===== rtl/cross_mean_filter_rgb_top.sv =====
// Pipeline: a result-producing request passes the read stage, then the output register.
// Throughput: one request per cycle when not stalled; the line stores are read at two
// addresses and written at one in every cycle, so a request can follow in the next cycle.
// Reset: rst_n is asynchronous and active low; it clears the counters, the
// valid flags and the registers to 640 by 480. Line stores are not cleared.
`default_nettype none

module cross_mean_filter_rgb_top #(
    parameter int MAX_WIDTH  = cmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cmf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration write channel: index 0 is image_width, 1 is image_height.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cmf_pkg::CFG_W-1:0]        cfg_data,
    // Input stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [cmf_pkg::PIX_W-1:0]        s_tdata,  // red_in, green_in, blue_in
    input  wire logic                             s_tuser,  // func
    // Output stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [cmf_pkg::PIX_W-1:0]        m_tdata,  // red_out, green_out, blue_out
    output logic                                  m_tlast   // last_pixel
);

    localparam int AW = $clog2(MAX_WIDTH);

    cmf_pkg::cmf_ctl_t         ctl;
    cmf_pkg::cmf_ctl_t         s1_ctl_reg;
    logic [cmf_pkg::PIX_W-1:0] s1_px_reg;
    logic                      s1_valid_reg;
    logic                      out_valid_reg;
    logic                      s_accept;
    logic                      out_load;
    logic [AW-1:0]             addr_a;
    logic [AW-1:0]             addr_b;
    logic                      wr_en_a;
    logic                      wr_en_b;
    logic [cmf_pkg::PIX_W-1:0] a_rd_a;
    logic [cmf_pkg::PIX_W-1:0] a_rd_b;
    logic [cmf_pkg::PIX_W-1:0] b_rd_a;
    logic [cmf_pkg::PIX_W-1:0] b_rd_b;
    logic [cmf_pkg::PIX_W-1:0] centre;
    logic [cmf_pkg::PIX_W-1:0] right;
    logic [cmf_pkg::PIX_W-1:0] up;

    // The host must write the registers only while idle; the block does not enforce it.
    assign cfg_ready = 1'b1;

    // The output register loads when empty or when its result is being taken.
    // The read stage advances with it, and an empty read stage takes a request even
    // while a finished result still waits at the output.
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    cmf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (s_accept),
        .func      (s_tuser),
        .ctl       (ctl),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .wr_en_a   (wr_en_a),
        .wr_en_b   (wr_en_b)
    );

    // Two line stores swap roles at the end of every row. The store that is
    // not the previous row receives the incoming pixel at its column.
    cmf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_store_a (
        .clk       (clk),
        .wr_en     (wr_en_a),
        .wr_addr   (addr_a),
        .wr_data   (s_tdata),
        .rd_en     (s_accept),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (a_rd_a),
        .rd_data_b (a_rd_b)
    );

    cmf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_store_b (
        .clk       (clk),
        .wr_en     (wr_en_b),
        .wr_addr   (addr_a),
        .wr_data   (s_tdata),
        .rd_en     (s_accept),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (b_rd_a),
        .rd_data_b (b_rd_b)
    );

    // Select clear means store A held the previous row when the request was taken.
    assign centre = s1_ctl_reg.sel ? b_rd_a : a_rd_a;
    assign right  = s1_ctl_reg.sel ? b_rd_b : a_rd_b;
    assign up     = s1_ctl_reg.sel ? a_rd_a : b_rd_a;

    cmf_mean u_mean (
        .clk      (clk),
        .load     (out_load && s1_valid_reg),
        .interior (s1_ctl_reg.interior),
        .drain    (s1_ctl_reg.drain),
        .last     (s1_ctl_reg.last),
        .centre   (centre),
        .right    (right),
        .up       (up),
        .down     (s1_px_reg),
        .pix      (m_tdata),
        .pix_last (m_tlast)
    );

    // Only requests that produce a result occupy the read stage; the others
    // finish with their counter and line-store updates at acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= ctl.emit;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_ctl_reg <= ctl;
            s1_px_reg  <= s_tdata;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef NO_ASSERTIONS
    // A held read stage behind a stalled output must block new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("request accepted while the read stage is blocked");

    // A request that produces a result lands in the read stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && ctl.emit) |=> s1_valid_reg)
        else $error("result-producing request lost at the read stage");

    // A result leaving the read stage reaches the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_load) |=> m_tvalid)
        else $error("result lost between read stage and output");

    // Only one line store takes the incoming pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en_a && wr_en_b))
        else $error("both line stores written in one cycle");
`endif

endmodule

`default_nettype wire
